// File: rtl/core/wca_pkg.sv
// Shared constants and types for the weighted centroid accumulator.
// Depends on nothing; every module in rtl/core imports it.
package wca_pkg;

   localparam int DIMS      = 8;
   localparam int DIM_W     = 3;
   localparam int VAL_W     = 32;
   localparam int WGT_W     = 32;
   localparam int TW_W      = 40;
   localparam int SUM_W     = TW_W + 1;
   localparam int MSQ_W     = 48;
   localparam int SQ_W      = 47;
   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 40;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int DIV_N_W   = NUM_W + 1;
   localparam int REQ_W     = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 88;

   localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SET    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ATTACH = 2'd2;

   localparam logic [MSQ_W-1:0] MEAN_POS_LIMIT = 48'h0000_7FFF_FFFF;
   localparam logic [MSQ_W-1:0] MEAN_NEG_LIMIT = 48'h0000_8000_0000;
   localparam logic [MSQ_W-1:0] MSQ_LIMIT      = 48'hFFFF_FFFF_FFFF;
   localparam logic [TW_W-1:0]  TW_LIMIT       = 40'hFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SQV,
      ST_T1,
      ST_T2,
      ST_COMB,
      ST_DIVM,
      ST_T3,
      ST_T4,
      ST_DIVQ,
      ST_VSQ,
      ST_WRITE
   } state_type;

   // Square of a Q16.16 magnitude, rounded to Q31.16.
   function automatic logic [SQ_W-1:0] sq16(input logic [PROD_W-1:0] p);
      logic [63:0] t;
      t = p[63:0] + 64'h8000;
      return t[16 +: SQ_W];
   endfunction

endpackage

// File: rtl/core/wca_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on wca_pkg for operand widths.
module wca_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wca_pkg::MUL_A_W-1:0] a,
   input  logic [wca_pkg::MUL_B_W-1:0] b,
   output logic                        done,
   output logic [wca_pkg::PROD_W-1:0]  product
);
   import wca_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [MUL_A_W:0]   sum;

   always_comb begin
      sum     = {1'b0, acc_ff[PROD_W-1:MUL_B_W]} + (b_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         // add, then shift one bit of the product down
         acc_in = {sum, acc_ff[MUL_B_W-1:1]};
         b_in   = {1'b0, b_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/core/wca_div.sv
// Radix-2 restoring divider with round-half-up and saturation to a limit.
// Depends on wca_pkg for operand widths.
module wca_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wca_pkg::NUM_W-1:0]   num,
   input  logic [wca_pkg::SUM_W-1:0]   den,
   input  logic [wca_pkg::MSQ_W-1:0]   limit,
   output logic                        done,
   output logic [wca_pkg::MSQ_W-1:0]   quotient
);
   import wca_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] n_ff, n_in;
   logic [SUM_W-1:0]   d_ff, d_in;
   logic [SUM_W-1:0]   r_ff, r_in;
   logic [MSQ_W-1:0]   q_ff, q_in;
   logic [MSQ_W-1:0]   lim_ff, lim_in;
   logic               ovf_ff, ovf_in;
   logic [SUM_W:0]     rt;
   logic [SUM_W:0]     diff;
   logic               ge;

   always_comb begin
      rt      = {r_ff, n_ff[DIV_N_W-1]};
      diff    = rt - {1'b0, d_ff};
      ge      = rt >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      lim_in  = lim_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = {1'b0, num} + DIV_N_W'(den >> 1);
         d_in    = den;
         r_in    = '0;
         q_in    = '0;
         lim_in  = limit;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         n_in   = {n_ff[DIV_N_W-2:0], 1'b0};
         r_in   = ge ? diff[SUM_W-1:0] : rt[SUM_W-1:0];
         q_in   = {q_ff[MSQ_W-2:0], ge};
         ovf_in = ovf_ff | q_ff[MSQ_W-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      lim_ff <= lim_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = (ovf_ff || (q_ff > lim_ff)) ? lim_ff : q_ff;

endmodule

// File: rtl/core/weighted_centroid_accumulator.sv
// Weighted centroid accumulator: per-dimension weighted mean and mean of squares.
// Work from request transfer to response valid: attach runs six products and two quotients,
// load or set two products, unused code or divide fault one, dimension out of range none;
// one item at a time, the next item is taken on return to idle, which comes as the response
// register loads. Each product runs on the shared bit-serial multiplier (issue, 40 bit steps,
// done) and each quotient on the radix-2 divider (issue, 90 bit steps, done).
// Synchronous active-high reset clears stores, total weight and handshakes, and sets every zero-variance flag.
module weighted_centroid_accumulator (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: dim_index[2:0], coordinate_value[34:3], point_weight[66:35], zero fill
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [wca_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [wca_pkg::REQ_W-1:0]      req_tuser,   // req_type[1:0]
   input  logic                           req_tlast,   // last_dim
   // rsp_tdata: dim_out[2:0], new_mean[34:3], new_mean_square[82:35],
   //            variance_zero[83], any_variance_zero[84], divide_fault[85], zero fill
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [wca_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import wca_pkg::*;

   // entry stores, one register row per dimension
   logic [VAL_W-1:0] mean_store_ff [DIMS];
   logic [MSQ_W-1:0] msq_store_ff  [DIMS];
   logic [DIMS-1:0]  zflags_ff;
   logic [TW_W-1:0]  tw_ff;

   state_type state_ff, state_in;

   // captured item
   logic [REQ_W-1:0] type_ff;
   logic [DIM_W-1:0] dim_ff;
   logic [VAL_W-1:0] v_ff;
   logic [WGT_W-1:0] w_ff;
   logic             last_ff;
   logic             inrange_ff;
   logic [VAL_W-1:0] vm_ff;
   logic             nv_ff;
   logic [VAL_W-1:0] cur_mean_ff;
   logic [MSQ_W-1:0] cur_msq_ff;

   // working registers
   logic [VAL_W-1:0] mm_ff;
   logic             nm_ff;
   logic [SUM_W-1:0] s_ff;
   logic             fault_ff;
   logic [SQ_W-1:0]  sqv_ff;
   logic [NUM_W-1:0] num_ff;
   logic             neg_ff;
   logic [VAL_W-1:0] new_mean_ff;
   logic [MSQ_W-1:0] new_msq_ff;
   logic             vz_ff;
   logic             issued_ff, issued_in;

   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // serial units
   logic               mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_num;
   logic [MSQ_W-1:0]   div_limit;
   logic [MSQ_W-1:0]   div_q;

   logic               req_fire, out_free, write_go;
   logic [SUM_W-1:0]   s_now;
   logic [VAL_W-1:0]   new_mag;
   logic [NUM_W-1:0]   t1_ext, t2_ext;
   logic [DIMS-1:0]    zflags_next;
   logic [VAL_W-1:0]   neg_q;

   wca_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   wca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (s_ff),
      .limit    (div_limit),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign write_go   = (state_ff == ST_WRITE) && out_free;
   assign s_now      = {1'b0, tw_ff} + SUM_W'(w_ff);
   assign new_mag    = new_mean_ff[VAL_W-1] ? (~new_mean_ff + 1'b1) : new_mean_ff;
   assign t1_ext     = num_ff;
   assign t2_ext     = NUM_W'(mul_p);
   assign div_num    = num_ff;
   assign div_limit  = (state_ff == ST_DIVM) ? (neg_ff ? MEAN_NEG_LIMIT : MEAN_POS_LIMIT)
                                             : MSQ_LIMIT;
   assign neg_q      = ~div_q[VAL_W-1:0] + 1'b1;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQV: begin
            mul_a = MUL_A_W'(vm_ff);
            mul_b = MUL_B_W'(vm_ff);
         end
         ST_T1: begin
            mul_a = MUL_A_W'(mm_ff);
            mul_b = tw_ff;
         end
         ST_T2: begin
            mul_a = MUL_A_W'(vm_ff);
            mul_b = MUL_B_W'(w_ff);
         end
         ST_T3: begin
            mul_a = cur_msq_ff;
            mul_b = tw_ff;
         end
         ST_T4: begin
            mul_a = MUL_A_W'(sqv_ff);
            mul_b = MUL_B_W'(w_ff);
         end
         ST_VSQ: begin
            mul_a = MUL_A_W'(new_mag);
            mul_b = MUL_B_W'(new_mag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer: next state and unit strobes
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (!inrange_ff) begin
               state_in = ST_WRITE;
            end else if (type_ff == REQ_LOAD || type_ff == REQ_SET) begin
               state_in = ST_SQV;
            end else if (type_ff == REQ_ATTACH && s_now != '0) begin
               state_in = ST_SQV;
            end else begin
               state_in = ST_VSQ;
            end
         end
         ST_SQV, ST_T1, ST_T2, ST_T3, ST_T4, ST_VSQ: begin
            mul_start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  ST_SQV:  state_in = (type_ff == REQ_ATTACH) ? ST_T1 : ST_VSQ;
                  ST_T1:   state_in = ST_T2;
                  ST_T2:   state_in = ST_COMB;
                  ST_T3:   state_in = ST_T4;
                  ST_T4:   state_in = ST_DIVQ;
                  default: state_in = ST_WRITE;
               endcase
            end
         end
         ST_COMB: begin
            state_in = ST_DIVM;
         end
         ST_DIVM, ST_DIVQ: begin
            div_start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               state_in  = (state_ff == ST_DIVM) ? ST_T3 : ST_VSQ;
            end
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // updated zero-variance flags for the response and the store
   always_comb begin
      zflags_next = zflags_ff;
      if (inrange_ff) zflags_next[dim_ff] = vz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zflags_ff    <= '1;
         tw_ff        <= '0;
         for (int i = 0; i < DIMS; i++) begin
            mean_store_ff[i] <= '0;
            msq_store_ff[i]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         // load a new response, or drop the old one once it transfers
         if (write_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (write_go) begin
            if (inrange_ff) begin
               mean_store_ff[dim_ff] <= new_mean_ff;
               msq_store_ff[dim_ff]  <= new_msq_ff;
               zflags_ff             <= zflags_next;
               // total weight moves only on the last coordinate
               if (last_ff && type_ff == REQ_LOAD) begin
                  tw_ff <= TW_W'(w_ff);
               end else if (last_ff && type_ff == REQ_ATTACH && !fault_ff) begin
                  tw_ff <= s_ff[TW_W] ? TW_LIMIT : s_ff[TW_W-1:0];
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff    <= req_tuser;
         dim_ff     <= req_tdata[DIM_W-1:0];
         v_ff       <= req_tdata[DIM_W +: VAL_W];
         w_ff       <= req_tdata[DIM_W+VAL_W +: WGT_W];
         last_ff    <= req_tlast;
         inrange_ff <= 32'(req_tdata[DIM_W-1:0]) < DIMS;
         nv_ff      <= req_tdata[DIM_W+VAL_W-1];
         vm_ff      <= req_tdata[DIM_W+VAL_W-1] ? (~req_tdata[DIM_W +: VAL_W] + 1'b1)
                                                : req_tdata[DIM_W +: VAL_W];
         cur_mean_ff <= mean_store_ff[req_tdata[DIM_W-1:0]];
         cur_msq_ff  <= msq_store_ff[req_tdata[DIM_W-1:0]];
      end
      unique case (state_ff)
         ST_PREP: begin
            nm_ff       <= cur_mean_ff[VAL_W-1];
            mm_ff       <= cur_mean_ff[VAL_W-1] ? (~cur_mean_ff + 1'b1) : cur_mean_ff;
            s_ff        <= s_now;
            fault_ff    <= (type_ff == REQ_ATTACH) && (s_now == '0);
            new_mean_ff <= inrange_ff ? cur_mean_ff : '0;
            new_msq_ff  <= inrange_ff ? cur_msq_ff : '0;
            vz_ff       <= 1'b0;
         end
         ST_SQV: begin
            if (issued_ff && mul_done) begin
               sqv_ff <= sq16(mul_p);
               if (type_ff != REQ_ATTACH) begin
                  new_mean_ff <= v_ff;
                  new_msq_ff  <= MSQ_W'(sq16(mul_p));
               end
            end
         end
         ST_T1: begin
            if (issued_ff && mul_done) num_ff <= NUM_W'(mul_p);
         end
         ST_COMB: begin
            // signed sum of the two weighted magnitudes, kept as sign and magnitude
            if (nm_ff == nv_ff) begin
               num_ff <= t1_ext + t2_ext;
               neg_ff <= nm_ff;
            end else if (t1_ext >= t2_ext) begin
               num_ff <= t1_ext - t2_ext;
               neg_ff <= nm_ff;
            end else begin
               num_ff <= t2_ext - t1_ext;
               neg_ff <= nv_ff;
            end
         end
         ST_DIVM: begin
            if (issued_ff && div_done) begin
               new_mean_ff <= neg_ff ? neg_q : div_q[VAL_W-1:0];
            end
         end
         ST_T3: begin
            if (issued_ff && mul_done) num_ff <= NUM_W'(mul_p);
         end
         ST_T4: begin
            if (issued_ff && mul_done) num_ff <= num_ff + NUM_W'(mul_p);
         end
         ST_DIVQ: begin
            if (issued_ff && div_done) new_msq_ff <= div_q;
         end
         ST_VSQ: begin
            if (issued_ff && mul_done) vz_ff <= (MSQ_W'(sq16(mul_p)) == new_msq_ff);
         end
         default: begin
         end
      endcase
      if (write_go) begin
         // pack the response fields from the lowest bit up, zero fill on top
         rsp_data_ff <= RSP_DATA_W'({inrange_ff && fault_ff, |zflags_next,
                                     inrange_ff && vz_ff, new_msq_ff, new_mean_ff, dim_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: bench/weighted_centroid_accumulator_checker.sv
// Checker for the weighted centroid accumulator: watches both stream channels,
// predicts each response from its own copy of the centroid state and compares.
// Depends on wca_pkg for widths and request codes.
`timescale 1ns / 100ps

module weighted_centroid_accumulator_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [wca_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [wca_pkg::REQ_W-1:0]      req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [wca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             fail_count,
   output int                             pending
);
   import wca_pkg::*;

   typedef struct packed {
      logic [DIM_W-1:0] dim;
      logic [31:0]      mean;
      logic [47:0]      msq;
      logic             var_zero;
      logic             any_zero;
      logic             fault;
   } centroid_update_type;

   logic [31:0] mean_copy [DIMS];
   logic [47:0] msq_copy [DIMS];
   logic        zero_copy [DIMS];
   logic [39:0] weight_copy;
   centroid_update_type expected_updates [$];

   function automatic logic [32:0] magnitude(input logic [31:0] v);
      return v[31] ? 33'h1_0000_0000 - {1'b0, v} : {1'b0, v};
   endfunction

   function automatic logic [46:0] square_q16(input logic [32:0] mag);
      logic [65:0] p;
      p = 66'(mag);
      p = p * p + 66'h8000;
      return p[62:16];
   endfunction

   // round half away from zero on a magnitude, then clamp
   function automatic logic [127:0] rounded_quotient(input logic [127:0] num,
         input logic [40:0] s, input logic [127:0] limit);
      logic [127:0] q;
      q = (num + 128'(s >> 1)) / 128'(s);
      return (q > limit) ? limit : q;
   endfunction

   function automatic centroid_update_type apply_update(input logic [1:0] kind,
         input logic [2:0] d, input logic [31:0] v, input logic [31:0] w, input logic last);
      centroid_update_type r;
      logic [40:0]  s;
      logic [32:0]  mm, vm;
      logic [127:0] t1, t2, num, q;
      logic         neg;
      r = '0;
      r.dim = d;
      if (kind == REQ_LOAD || kind == REQ_SET) begin
         mean_copy[d] = v;
         msq_copy[d] = {1'b0, square_q16(magnitude(v))};
         if (kind == REQ_LOAD && last) weight_copy = 40'(w);
      end else if (kind == REQ_ATTACH) begin
         s = {1'b0, weight_copy} + {9'b0, w};
         if (s == 0) begin
            r.fault = 1'b1;
         end else begin
            mm = magnitude(mean_copy[d]);
            vm = magnitude(v);
            t1 = 128'(weight_copy) * 128'(mm);
            t2 = 128'(w) * 128'(vm);
            if (mean_copy[d][31] == v[31]) begin
               num = t1 + t2;
               neg = v[31];
            end else if (t1 >= t2) begin
               num = t1 - t2;
               neg = mean_copy[d][31];
            end else begin
               num = t2 - t1;
               neg = v[31];
            end
            if (neg) begin
               q = rounded_quotient(num, s, 128'h8000_0000);
               mean_copy[d] = 32'(0) - q[31:0];
            end else begin
               q = rounded_quotient(num, s, 128'h7FFF_FFFF);
               mean_copy[d] = q[31:0];
            end
            num = 128'(weight_copy) * 128'(msq_copy[d])
                + 128'(w) * 128'(square_q16(vm));
            q = rounded_quotient(num, s, 128'hFFFF_FFFF_FFFF);
            msq_copy[d] = q[47:0];
            if (last) weight_copy = (s > 41'hFF_FFFF_FFFF) ? TW_LIMIT : s[39:0];
         end
      end
      zero_copy[d] = ({1'b0, square_q16(magnitude(mean_copy[d]))} == msq_copy[d]);
      r.mean = mean_copy[d];
      r.msq = msq_copy[d];
      r.var_zero = zero_copy[d];
      for (int i = 0; i < DIMS; i++) r.any_zero |= zero_copy[i];
      return r;
   endfunction

   task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
      fail_count++;
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
   endtask

   initial fail_count = 0;
   assign pending = expected_updates.size();

   always @(posedge clock) begin
      centroid_update_type want, got;
      if (reset) begin
         for (int i = 0; i < DIMS; i++) begin
            mean_copy[i] = '0;
            msq_copy[i] = '0;
            zero_copy[i] = 1'b1;
         end
         weight_copy = '0;
         expected_updates.delete();
      end else begin
         // check the response first; a new request transfer follows it in order
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[82:35],
                   rsp_tdata[83], rsp_tdata[84], rsp_tdata[85]};
            if (expected_updates.size() == 0) begin
               report("unexpected response", '0, rsp_tdata[63:0]);
            end else begin
               want = expected_updates.pop_front();
               if (got.dim != want.dim) report("dim_out", 64'(want.dim), 64'(got.dim));
               if (got.mean != want.mean)
                  report("new_mean", 64'(want.mean), 64'(got.mean));
               if (got.msq != want.msq)
                  report("new_mean_square", 64'(want.msq), 64'(got.msq));
               if (got.var_zero != want.var_zero)
                  report("variance_zero", 64'(want.var_zero), 64'(got.var_zero));
               if (got.any_zero != want.any_zero)
                  report("any_variance_zero", 64'(want.any_zero), 64'(got.any_zero));
               if (got.fault != want.fault)
                  report("divide_fault", 64'(want.fault), 64'(got.fault));
            end
         end
         if (req_tvalid && req_tready)
            expected_updates.push_back(apply_update(req_tuser, req_tdata[2:0],
               req_tdata[34:3], req_tdata[66:35], req_tlast));
      end
   end

endmodule

// File: bench/weighted_centroid_accumulator_test.sv
// Top of the weighted centroid accumulator bench: clock, reset, stimulus and verdict.
// Depends on wca_pkg, the accumulator RTL and weighted_centroid_accumulator_checker.
`timescale 1ns / 100ps

module weighted_centroid_accumulator_test;
   import wca_pkg::*;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;   // code with no operation

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // dim_index, coordinate_value, point_weight
   logic [REQ_W-1:0]      req_tuser = '0;   // req_type
   logic                  req_tlast = 1'b0; // last_dim
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // dim_out, mean, mean_square, flags
   int                    fail_count, pending;
   int                    cycle_count = 0;
   int                    sent_count = 0;
   int                    attach_count = 0;
   int                    point_count = 0;

   always #6 clock = ~clock;

   weighted_centroid_accumulator uut (.*);

   weighted_centroid_accumulator_checker check (.*);

   // Hard stop if the block hangs anywhere.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Coordinate mix: full range, small magnitudes, and the rails.
   function automatic logic [31:0] pick_coordinate();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($signed($urandom_range(0, 20)) - 10) << 16;
         4, 5:    return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   // Weight mix: mostly moderate so means move, sometimes zero or huge.
   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(1, 8) << 16;
      endcase
   endfunction

   // Offer one transfer after a random gap; hold valid across back-to-back items.
   task automatic send_item(input logic [1:0] kind, input logic [2:0] d,
         input logic [31:0] v, input logic [31:0] w, input logic last);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {5'b0, w, v, d};
      req_tuser <= kind;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_count++;
      if (kind == REQ_ATTACH) attach_count++;
   endtask

   // Send a whole point of ndims coordinates, the last one flagged.
   task automatic send_point(input logic [1:0] kind, input int ndims);
      logic [31:0] w;
      w = pick_weight();
      for (int i = 0; i < ndims; i++)
         send_item(kind, 3'(i), pick_coordinate(), w, i == ndims - 1);
      point_count++;
   endtask

   // Receiver: random stalls, one long hold-off to back the block up.
   initial begin
      int gap, taken;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = (taken == 40) ? 3000 : $urandom_range(0, 10);
         if (taken > 600 && taken < 700) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         taken++;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fault on empty centre, rails, every code, weight extremes.
      send_item(REQ_ATTACH, 3'd0, 32'h0001_0000, 32'h0, 1'b1);
      send_item(REQ_LOAD, 3'd0, 32'h7FFF_FFFF, 32'h0, 1'b1);
      send_item(REQ_ATTACH, 3'd0, 32'h8000_0000, 32'h0, 1'b1);
      send_item(REQ_LOAD, 3'd7, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      send_item(REQ_SET, 3'd3, 32'hFFFF_FFFF, 32'h0, 1'b0);
      send_item(REQ_SPARE, 3'd2, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
      send_item(REQ_ATTACH, 3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_item(REQ_ATTACH, 3'd7, 32'h8000_0000, 32'h0001_0000, 1'b1);
      send_item(REQ_ATTACH, 3'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      send_item(REQ_ATTACH, 3'd3, 32'h0000_0001, 32'h0000_0001, 1'b1);
      send_item(REQ_SET, 3'd5, 32'h0, 32'h5555_5555, 1'b1);
      send_item(REQ_LOAD, 3'd1, 32'h0000_8000, 32'h0000_0001, 1'b1);
      send_item(REQ_ATTACH, 3'd1, 32'hFFFF_8000, 32'h0000_0001, 1'b1);
      send_item(REQ_ATTACH, 3'd4, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b1);
      send_item(REQ_ATTACH, 3'd6, 32'h5555_5555, 32'h0, 1'b0);

      // Random: load a point, then merge points into it; some noise.
      while (sent_count < RANDOM_ITEMS) begin
         send_point(REQ_LOAD, $urandom_range(1, DIMS));
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0:       send_point(REQ_SET, $urandom_range(1, DIMS));
               1:       send_item(REQ_SPARE, 3'($urandom), $urandom, $urandom,
                                  1'($urandom));
               2:       send_item(REQ_ATTACH, 3'($urandom), pick_coordinate(),
                                  pick_weight(), 1'($urandom));
               default: send_point(REQ_ATTACH, $urandom_range(1, DIMS));
            endcase
         end
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      $display("run covered %0d items in %0d points, %0d attaches, over %0d cycles",
               sent_count, point_count, attach_count, cycle_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
